>>> rtl/core/assert_macros.svh
// assertion helpers used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define SPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/core/h264sps_pkg.sv
`default_nettype none

package h264sps_pkg;

    // defaults for the top level parameters
    localparam int HEADER_SKIP_BYTES_DEF = 3;
    localparam int MAX_GOLOMB_BITS_DEF   = 32;

    // byte queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // field widths
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 5;
    localparam int POC_W    = 2;

    // size field handling
    localparam int                MINUS4_MAX     = 12;
    localparam logic [SIZE_W-1:0] SIZE_BIAS      = 5'd4;
    localparam logic [SIZE_W-1:0] SIZE_SAT       = 5'd16;
    localparam logic [SIZE_W-1:0] FRAME_NUM_RST  = 5'd4;
    localparam logic [SIZE_W-1:0] POC_LSB_RST    = 5'd5;

    // syntax element being read
    typedef enum logic [3:0] {
        FS_SPS_ID,
        FS_FRAME_NUM,
        FS_POC_TYPE,
        FS_POC_LSB,
        FS_DELTA_FLAG,
        FS_OFF_NONREF,
        FS_OFF_TOPBOT,
        FS_CYCLE_LEN,
        FS_CYCLE_ENTRY,
        FS_REF_COUNT,
        FS_GAP_FLAG,
        FS_WIDTH,
        FS_HEIGHT,
        FS_MBS_ONLY
    } field_step_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_BAD_POC,
        ST_TRUNC,
        ST_SIZE
    } status_t;

    // picture order count type as reported
    typedef enum logic [POC_W-1:0] {
        POC_T0,
        POC_T1,
        POC_T2,
        POC_BAD
    } poc_kind_t;

    // bit engine states
    typedef enum logic [1:0] {
        B_IDLE,
        B_BITS,
        B_LAST
    } back_state_t;

    // one queued byte, tagged by the front
    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
        logic              skip;
    } q_entry_t;

    // queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/h264sps_ifs.sv
`default_nettype none

// byte stream channel
interface h264sps_in_if import h264sps_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// result channel
interface h264sps_out_if import h264sps_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   log2_frame_num_size;
    logic [POC_W-1:0]    poc_kind;
    logic [SIZE_W-1:0]   log2_poc_lsb_size;
    logic                frame_mbs_only;

    modport source (output valid, output status, output log2_frame_num_size,
                    output poc_kind, output log2_poc_lsb_size, output frame_mbs_only,
                    input ready);
    modport sink   (input valid, input status, input log2_frame_num_size,
                    input poc_kind, input log2_poc_lsb_size, input frame_mbs_only,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/h264sps_queue.sv
`default_nettype none

module h264sps_queue import h264sps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t wr_data,
    input  logic     pop,
    output q_entry_t rd_data,
    output q_flags_t flags
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    q_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // occupancy
    assign flags.full  = (count_reg == CNT_FULL);
    assign flags.empty = (count_reg == '0);
    assign rd_data     = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/h264sps_front.sv
`default_nettype none

module h264sps_front import h264sps_pkg::*;
#(
    parameter int HEADER_SKIP_BYTES = HEADER_SKIP_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    h264sps_in_if.sink        payload,
    input  q_flags_t          q_flags,
    output logic              q_push,
    output q_entry_t          q_wr_data
);

    localparam int HDR_W = (HEADER_SKIP_BYTES > 0) ? $clog2(HEADER_SKIP_BYTES + 1) : 1;
    localparam logic [HDR_W-1:0] HDR_LIMIT = HDR_W'(HEADER_SKIP_BYTES);

    logic [HDR_W-1:0] hdr_cnt_reg;
    logic [HDR_W-1:0] hdr_cnt_next;
    logic             in_header;

    // take a request whenever the queue has room
    assign payload.ready = !q_flags.full;
    assign q_push        = payload.valid && !q_flags.full;
    assign in_header     = (hdr_cnt_reg < HDR_LIMIT);

    // tag header bytes so the back drops them
    assign q_wr_data.data_byte = payload.data_byte;
    assign q_wr_data.last_byte = payload.last_byte;
    assign q_wr_data.skip      = in_header;

    // header byte count, restarts with each parameter set
    always_comb
    begin
        hdr_cnt_next = hdr_cnt_reg;
        if (q_push)
        begin
            if (payload.last_byte)
            begin
                hdr_cnt_next = '0;
            end
            else if (in_header)
            begin
                hdr_cnt_next = hdr_cnt_reg + HDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg <= '0;
        end
        else
        begin
            hdr_cnt_reg <= hdr_cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/h264sps_back.sv
`default_nettype none

module h264sps_back import h264sps_pkg::*;
#(
    parameter int MAX_GOLOMB_BITS = MAX_GOLOMB_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  q_entry_t      q_data,
    input  q_flags_t      q_flags,
    output logic          q_pop,
    h264sps_out_if.source result
);

    localparam int ACC_W = MAX_GOLOMB_BITS;
    localparam int LZ_W  = $clog2(MAX_GOLOMB_BITS);
    localparam logic [LZ_W-1:0]  LZ_MAX   = LZ_W'(MAX_GOLOMB_BITS - 1);
    localparam logic [ACC_W-1:0] ACC_ONE  = ACC_W'(1);
    localparam logic [ACC_W-1:0] VAL_ONE  = ACC_W'(1);
    localparam logic [ACC_W-1:0] VAL_TWO  = ACC_W'(2);
    localparam logic [ACC_W-1:0] VAL_SMAX = ACC_W'(MINUS4_MAX);

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [DATA_W-1:0] byte_reg;
    logic [DATA_W-1:0] byte_next;
    logic              last_reg;
    logic              last_next;
    logic [2:0]        bit_idx_reg;
    logic [2:0]        bit_idx_next;

    field_step_t       step_reg;
    field_step_t       step_next;
    logic              phase_reg;
    logic              phase_next;
    logic [LZ_W-1:0]   lz_reg;
    logic [LZ_W-1:0]   lz_next;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [ACC_W-1:0]  cyc_reg;
    logic [ACC_W-1:0]  cyc_next;
    logic [SIZE_W-1:0] fn_reg;
    logic [SIZE_W-1:0] fn_next;
    poc_kind_t         poc_reg;
    poc_kind_t         poc_next;
    logic [SIZE_W-1:0] lsb_reg;
    logic [SIZE_W-1:0] lsb_next;
    logic              sent_reg;
    logic              sent_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           out_status_reg;
    status_t           out_status_next;
    logic [SIZE_W-1:0] out_fn_reg;
    logic [SIZE_W-1:0] out_fn_next;
    poc_kind_t         out_poc_reg;
    poc_kind_t         out_poc_next;
    logic [SIZE_W-1:0] out_lsb_reg;
    logic [SIZE_W-1:0] out_lsb_next;
    logic              out_mbs_reg;
    logic              out_mbs_next;

    // one-bit step results
    logic              bit_val;
    field_step_t       b_step;
    logic              b_phase;
    logic [LZ_W-1:0]   b_lz;
    logic [ACC_W-1:0]  b_acc;
    logic [ACC_W-1:0]  b_cyc;
    logic [SIZE_W-1:0] b_fn;
    poc_kind_t         b_poc;
    logic [SIZE_W-1:0] b_lsb;
    logic              b_emit;
    status_t           b_status;
    logic              b_mbs;
    logic              f_done;
    logic [ACC_W-1:0]  f_val;
    logic [ACC_W-1:0]  acc_shift;
    logic [LZ_W-1:0]   lz_dec;
    logic [ACC_W-1:0]  cyc_dec;

    logic              out_can_load;
    logic              bits_adv;
    logic              last_adv;
    logic              bits_end;

    assign bit_val      = byte_reg[bit_idx_reg];
    assign acc_shift    = {acc_reg[ACC_W-2:0], bit_val};
    assign lz_dec       = lz_reg - LZ_W'(1);
    assign cyc_dec      = (cyc_reg != '0) ? cyc_reg - ACC_ONE : cyc_reg;
    assign out_can_load = !out_valid_reg || result.ready;
    assign bits_adv     = !b_emit || out_can_load;
    assign last_adv     = sent_reg || out_can_load;
    assign bits_end     = b_emit || (bit_idx_reg == '0);

    // exp-golomb reader: effect of the current bit
    always_comb
    begin
        b_step   = step_reg;
        b_phase  = phase_reg;
        b_lz     = lz_reg;
        b_acc    = acc_reg;
        b_cyc    = cyc_reg;
        b_fn     = fn_reg;
        b_poc    = poc_reg;
        b_lsb    = lsb_reg;
        b_emit   = 1'b0;
        b_status = ST_OK;
        b_mbs    = 1'b0;
        f_done   = 1'b0;
        f_val    = '0;

        case (step_reg)
            FS_DELTA_FLAG:
            begin
                b_step = FS_OFF_NONREF;
            end
            FS_GAP_FLAG:
            begin
                b_step = FS_WIDTH;
            end
            FS_MBS_ONLY:
            begin
                b_emit   = 1'b1;
                b_status = ST_OK;
                b_mbs    = bit_val;
            end
            default:
            begin
                if (!phase_reg)
                begin
                    if (!bit_val)
                    begin
                        // overlong prefix counts as a broken stream
                        if (lz_reg >= LZ_MAX)
                        begin
                            b_emit   = 1'b1;
                            b_status = ST_TRUNC;
                        end
                        else
                        begin
                            b_lz = lz_reg + LZ_W'(1);
                        end
                    end
                    else if (lz_reg == '0)
                    begin
                        f_done = 1'b1;
                    end
                    else
                    begin
                        b_phase = 1'b1;
                        b_acc   = ACC_ONE;
                    end
                end
                else
                begin
                    b_acc = acc_shift;
                    b_lz  = lz_dec;
                    if (lz_dec == '0)
                    begin
                        b_phase = 1'b0;
                        f_done  = 1'b1;
                        f_val   = acc_shift - ACC_ONE;
                    end
                end
            end
        endcase

        // act on a completed code
        if (f_done)
        begin
            case (step_reg)
                FS_SPS_ID:
                begin
                    b_step = FS_FRAME_NUM;
                end
                FS_FRAME_NUM:
                begin
                    if (f_val > VAL_SMAX)
                    begin
                        b_fn     = SIZE_SAT;
                        b_emit   = 1'b1;
                        b_status = ST_SIZE;
                    end
                    else
                    begin
                        b_fn   = SIZE_W'(f_val) + SIZE_BIAS;
                        b_step = FS_POC_TYPE;
                    end
                end
                FS_POC_TYPE:
                begin
                    if (f_val == '0)
                    begin
                        b_poc  = POC_T0;
                        b_step = FS_POC_LSB;
                    end
                    else if (f_val == VAL_ONE)
                    begin
                        b_poc  = POC_T1;
                        b_step = FS_DELTA_FLAG;
                    end
                    else if (f_val == VAL_TWO)
                    begin
                        b_poc  = POC_T2;
                        b_step = FS_REF_COUNT;
                    end
                    else
                    begin
                        b_poc    = POC_BAD;
                        b_emit   = 1'b1;
                        b_status = ST_BAD_POC;
                    end
                end
                FS_POC_LSB:
                begin
                    if (f_val > VAL_SMAX)
                    begin
                        b_lsb    = SIZE_SAT;
                        b_emit   = 1'b1;
                        b_status = ST_SIZE;
                    end
                    else
                    begin
                        b_lsb  = SIZE_W'(f_val) + SIZE_BIAS;
                        b_step = FS_REF_COUNT;
                    end
                end
                FS_OFF_NONREF:
                begin
                    b_step = FS_OFF_TOPBOT;
                end
                FS_OFF_TOPBOT:
                begin
                    b_step = FS_CYCLE_LEN;
                end
                FS_CYCLE_LEN:
                begin
                    b_cyc  = f_val;
                    b_step = (f_val != '0) ? FS_CYCLE_ENTRY : FS_REF_COUNT;
                end
                FS_CYCLE_ENTRY:
                begin
                    b_cyc = cyc_dec;
                    if (cyc_dec == '0)
                    begin
                        b_step = FS_REF_COUNT;
                    end
                end
                FS_REF_COUNT:
                begin
                    b_step = FS_GAP_FLAG;
                end
                FS_WIDTH:
                begin
                    b_step = FS_HEIGHT;
                end
                FS_HEIGHT:
                begin
                    b_step = FS_MBS_ONLY;
                end
                default:
                begin
                    b_step = step_reg;
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_flags.empty)
                begin
                    if (q_data.skip || sent_reg)
                    begin
                        state_next = q_data.last_byte ? B_LAST : B_IDLE;
                    end
                    else
                    begin
                        state_next = B_BITS;
                    end
                end
            end
            B_BITS:
            begin
                if (bits_adv && bits_end)
                begin
                    state_next = last_reg ? B_LAST : B_IDLE;
                end
            end
            B_LAST:
            begin
                if (last_adv)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // datapath and result register updates
    always_comb
    begin
        q_pop           = 1'b0;
        byte_next       = byte_reg;
        last_next       = last_reg;
        bit_idx_next    = bit_idx_reg;
        step_next       = step_reg;
        phase_next      = phase_reg;
        lz_next         = lz_reg;
        acc_next        = acc_reg;
        cyc_next        = cyc_reg;
        fn_next         = fn_reg;
        poc_next        = poc_reg;
        lsb_next        = lsb_reg;
        sent_next       = sent_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_status_next = out_status_reg;
        out_fn_next     = out_fn_reg;
        out_poc_next    = out_poc_reg;
        out_lsb_next    = out_lsb_reg;
        out_mbs_next    = out_mbs_reg;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_flags.empty)
                begin
                    q_pop        = 1'b1;
                    byte_next    = q_data.data_byte;
                    last_next    = q_data.last_byte;
                    bit_idx_next = 3'd7;
                end
            end
            B_BITS:
            begin
                if (bits_adv)
                begin
                    step_next    = b_step;
                    phase_next   = b_phase;
                    lz_next      = b_lz;
                    acc_next     = b_acc;
                    cyc_next     = b_cyc;
                    fn_next      = b_fn;
                    poc_next     = b_poc;
                    lsb_next     = b_lsb;
                    bit_idx_next = bit_idx_reg - 3'd1;
                    if (b_emit)
                    begin
                        sent_next       = 1'b1;
                        out_valid_next  = 1'b1;
                        out_status_next = b_status;
                        out_fn_next     = b_fn;
                        out_poc_next    = b_poc;
                        out_lsb_next    = b_lsb;
                        out_mbs_next    = b_mbs;
                    end
                end
            end
            B_LAST:
            begin
                // end of set: report truncation if nothing went out yet
                if (!sent_reg && out_can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_TRUNC;
                    out_fn_next     = fn_reg;
                    out_poc_next    = poc_reg;
                    out_lsb_next    = lsb_reg;
                    out_mbs_next    = 1'b0;
                end
                if (last_adv)
                begin
                    step_next  = FS_SPS_ID;
                    phase_next = 1'b0;
                    lz_next    = '0;
                    acc_next   = '0;
                    cyc_next   = '0;
                    fn_next    = FRAME_NUM_RST;
                    poc_next   = POC_T0;
                    lsb_next   = POC_LSB_RST;
                    sent_next  = 1'b0;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // control and parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= FS_SPS_ID;
            phase_reg     <= 1'b0;
            lz_reg        <= '0;
            acc_reg       <= '0;
            cyc_reg       <= '0;
            fn_reg        <= FRAME_NUM_RST;
            poc_reg       <= POC_T0;
            lsb_reg       <= POC_LSB_RST;
            sent_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            lz_reg        <= lz_next;
            acc_reg       <= acc_next;
            cyc_reg       <= cyc_next;
            fn_reg        <= fn_next;
            poc_reg       <= poc_next;
            lsb_reg       <= lsb_next;
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // byte buffer and result payload
    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        bit_idx_reg    <= bit_idx_next;
        out_status_reg <= out_status_next;
        out_fn_reg     <= out_fn_next;
        out_poc_reg    <= out_poc_next;
        out_lsb_reg    <= out_lsb_next;
        out_mbs_reg    <= out_mbs_next;
    end

    // result channel
    assign result.valid               = out_valid_reg;
    assign result.status              = out_status_reg;
    assign result.log2_frame_num_size = out_fn_reg;
    assign result.poc_kind            = out_poc_reg;
    assign result.log2_poc_lsb_size   = out_lsb_reg;
    assign result.frame_mbs_only      = out_mbs_reg;

endmodule

`default_nettype wire

>>> rtl/core/h264sps_field_parser.sv
// channel   dir   payload                                           role
// payload   in    data_byte[7:0], last_byte                         sps bytes, msb first
// result    out   status[1:0], log2_frame_num_size[4:0], poc_kind,  one per parameter set
//                 log2_poc_lsb_size[4:0], frame_mbs_only
//
// the bit reader loads a parsed byte from the queue, then reads its bits until the byte
// ends or a result goes out; a header byte or a byte after the result is only popped.
// after the final byte of a set, a last state reports truncation if no result went out
// yet and clears the parse state.
// a two-entry byte queue lets the front keep taking requests while the reader works.
// a result waits in the output register; the reader stalls only when it must emit another.
// reset is asynchronous, active low; there is no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module h264_sps_field_parser import h264sps_pkg::*;
#(
    parameter int HEADER_SKIP_BYTES = HEADER_SKIP_BYTES_DEF,
    parameter int MAX_GOLOMB_BITS   = MAX_GOLOMB_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    h264sps_in_if.sink    payload,
    h264sps_out_if.source result
);

    q_flags_t q_flags;
    q_entry_t q_wr_data;
    q_entry_t q_rd_data;
    logic     q_push;
    logic     q_pop;

    // front: take bytes, tag header bytes
    h264sps_front #(
        .HEADER_SKIP_BYTES (HEADER_SKIP_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .payload   (payload),
        .q_flags   (q_flags),
        .q_push    (q_push),
        .q_wr_data (q_wr_data)
    );

    // byte queue
    h264sps_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .flags   (q_flags)
    );

    // back: bit-serial exp-golomb reader and result register
    h264sps_back #(
        .MAX_GOLOMB_BITS (MAX_GOLOMB_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_rd_data),
        .q_flags (q_flags),
        .q_pop   (q_pop),
        .result  (result)
    );

    // checks
    `SPS_ASSERT_IMP(a_no_push_full, clk, rst_n, q_push, !q_flags.full)
    `SPS_ASSERT_NEXT(a_push_fills, clk, rst_n, q_push && q_flags.empty, !q_flags.empty)
    `SPS_ASSERT_IMP(a_err_no_mbs, clk, rst_n, result.valid && (result.status != ST_OK), !result.frame_mbs_only)
    `SPS_ASSERT_IMP(a_bad_poc_code, clk, rst_n, result.valid && (result.status == ST_BAD_POC), result.poc_kind == POC_BAD)

endmodule

`default_nettype wire

>>> dv/h264_sps_field_parser_checker.sv
`default_nettype none

module h264_sps_field_parser_checker
    import h264sps_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    h264sps_in_if  payload,
    h264sps_out_if result,
    output int     fail_count,
    output int     pending,
    output int     results_seen,
    output int     error_results
);

    // one decoded parameter set summary
    typedef struct {
        status_t           status;
        logic [SIZE_W-1:0] fn_size;
        poc_kind_t         poc;
        logic [SIZE_W-1:0] lsb_size;
        logic              mbs;
    } sps_summary_t;

    // parse state of the set in flight
    int unsigned       hdr_seen;
    field_step_t       step;
    logic              in_suffix;
    int unsigned       zeros;
    logic [31:0]       code_acc;
    logic [31:0]       entries_left;
    logic [SIZE_W-1:0] held_fn;
    poc_kind_t         held_poc;
    logic [SIZE_W-1:0] held_lsb;
    logic              reported;

    sps_summary_t summary_q[$];

    function automatic void clear_parse();
        hdr_seen     = 0;
        step         = FS_SPS_ID;
        in_suffix    = 1'b0;
        zeros        = 0;
        code_acc     = '0;
        entries_left = '0;
        held_fn      = FRAME_NUM_RST;
        held_poc     = POC_T0;
        held_lsb     = POC_LSB_RST;
        reported     = 1'b0;
    endfunction

    function automatic void push_summary(input status_t st, input logic mbs);
        summary_q.push_back('{status: st, fn_size: held_fn, poc: held_poc,
                              lsb_size: held_lsb, mbs: mbs});
        reported = 1'b1;
    endfunction

    // act on a finished ue(v) for the current syntax element
    function automatic void syntax_value(input logic [31:0] v);
        case (step)
            FS_SPS_ID:
                step = FS_FRAME_NUM;
            FS_FRAME_NUM:
            begin
                if (v > 32'(MINUS4_MAX))
                begin
                    held_fn = SIZE_SAT;
                    push_summary(ST_SIZE, 1'b0);
                end
                else
                begin
                    held_fn = v[SIZE_W-1:0] + SIZE_BIAS;
                    step    = FS_POC_TYPE;
                end
            end
            FS_POC_TYPE:
            begin
                if (v == 32'd0)
                begin
                    held_poc = POC_T0;
                    step     = FS_POC_LSB;
                end
                else if (v == 32'd1)
                begin
                    held_poc = POC_T1;
                    step     = FS_DELTA_FLAG;
                end
                else if (v == 32'd2)
                begin
                    held_poc = POC_T2;
                    step     = FS_REF_COUNT;
                end
                else
                begin
                    held_poc = POC_BAD;
                    push_summary(ST_BAD_POC, 1'b0);
                end
            end
            FS_POC_LSB:
            begin
                if (v > 32'(MINUS4_MAX))
                begin
                    held_lsb = SIZE_SAT;
                    push_summary(ST_SIZE, 1'b0);
                end
                else
                begin
                    held_lsb = v[SIZE_W-1:0] + SIZE_BIAS;
                    step     = FS_REF_COUNT;
                end
            end
            FS_OFF_NONREF:
                step = FS_OFF_TOPBOT;
            FS_OFF_TOPBOT:
                step = FS_CYCLE_LEN;
            FS_CYCLE_LEN:
            begin
                entries_left = v;
                step = (v != 32'd0) ? FS_CYCLE_ENTRY : FS_REF_COUNT;
            end
            FS_CYCLE_ENTRY:
            begin
                if (entries_left > 32'd0)
                    entries_left = entries_left - 32'd1;
                if (entries_left == 32'd0)
                    step = FS_REF_COUNT;
            end
            FS_REF_COUNT:
                step = FS_GAP_FLAG;
            FS_WIDTH:
                step = FS_HEIGHT;
            FS_HEIGHT:
                step = FS_MBS_ONLY;
            default:
                ;
        endcase
    endfunction

    // one bit of the payload, msb first
    function automatic void consume_bit(input logic b);
        if (step == FS_DELTA_FLAG)
        begin
            step = FS_OFF_NONREF;
            return;
        end
        if (step == FS_GAP_FLAG)
        begin
            step = FS_WIDTH;
            return;
        end
        if (step == FS_MBS_ONLY)
        begin
            push_summary(ST_OK, b);
            return;
        end
        // prefix: count zeros up to the marker bit
        if (!in_suffix)
        begin
            if (b == 1'b0)
            begin
                if (zeros >= MAX_GOLOMB_BITS_DEF - 1)
                    push_summary(ST_TRUNC, 1'b0);
                else
                    zeros++;
                return;
            end
            if (zeros == 0)
            begin
                syntax_value(32'd0);
                return;
            end
            in_suffix = 1'b1;
            code_acc  = 32'd1;
            return;
        end
        // suffix bits
        code_acc = {code_acc[30:0], b};
        zeros--;
        if (zeros == 0)
        begin
            in_suffix = 1'b0;
            syntax_value(code_acc - 32'd1);
        end
    endfunction

    function automatic void consume_byte(input logic [DATA_W-1:0] d, input logic l);
        if (!reported)
        begin
            if (hdr_seen < HEADER_SKIP_BYTES_DEF)
                hdr_seen++;
            else
                for (int i = DATA_W - 1; i >= 0 && !reported; i--)
                    consume_bit(d[i]);
        end
        // end of set: report truncation if nothing came out yet
        if (l)
        begin
            if (!reported)
                push_summary(ST_TRUNC, 1'b0);
            clear_parse();
        end
    endfunction

    function automatic void check_result();
        sps_summary_t want;
        bit           bad;
        if (summary_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t unexpected result: status=%0d fn=%0d poc=%0d lsb=%0d mbs=%0b",
                         $time, result.status, result.log2_frame_num_size,
                         result.poc_kind, result.log2_poc_lsb_size, result.frame_mbs_only);
            return;
        end
        want = summary_q.pop_front();
        results_seen++;
        if (want.status != ST_OK)
            error_results++;
        bad = (result.status !== want.status)
           || (result.log2_frame_num_size !== want.fn_size)
           || (result.poc_kind !== want.poc)
           || (result.log2_poc_lsb_size !== want.lsb_size)
           || (result.frame_mbs_only !== want.mbs);
        if (bad)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t mismatch: want status=%s fn=%0d poc=%s lsb=%0d mbs=%0b, %s%0d %s%0d %s%0d %s%0d %s%0b",
                         $time, want.status.name(), want.fn_size, want.poc.name(),
                         want.lsb_size, want.mbs,
                         "got status=", result.status, "fn=", result.log2_frame_num_size,
                         "poc=", result.poc_kind, "lsb=", result.log2_poc_lsb_size,
                         "mbs=", result.frame_mbs_only);
        end
    endfunction

    // predict on each accepted request, compare each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            summary_q.delete();
            fail_count    = 0;
            pending       = 0;
            results_seen  = 0;
            error_results = 0;
        end
        else
        begin
            if (payload.valid && payload.ready)
                consume_byte(payload.data_byte, payload.last_byte);
            if (result.valid && result.ready)
                check_result();
            pending = summary_q.size();
        end
    end

endmodule

`default_nettype wire

>>> dv/h264_sps_field_parser_test.sv
`default_nettype none

module h264_sps_field_parser_test;
    import h264sps_pkg::*;

    localparam int ITEM_TARGET  = 1650;
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              last;
    } sps_byte_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    h264sps_in_if  payload ();
    h264sps_out_if result ();

    int        fail_count;
    int        pending;
    int        results_seen;
    int        error_results;
    int        bytes_sent  = 0;
    int        sets_sent   = 0;
    int        burst_left  = 0;
    int        quiet_cycles = 0;
    bit        hold_req    = 1'b0;
    bit        filler_small = 1'b0;
    sps_byte_t byte_q[$];
    bit        bit_q[$];

    always #2 clk = ~clk;

    h264_sps_field_parser u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (payload),
        .result  (result)
    );

    h264_sps_field_parser_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .payload       (payload),
        .result        (result),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .error_results (error_results)
    );

    // value generators for the syntax elements
    function automatic logic [31:0] filler_value();
        int r;
        r = $urandom_range(0, 99);
        if (filler_small || r < 70)
            return $urandom_range(0, 3);
        if (r < 95)
            return $urandom_range(0, 255);
        if (r == 99)
            return 32'hFFFF_FFFE;
        return $urandom & ((32'd1 << $urandom_range(1, 31)) - 32'd1);
    endfunction

    function automatic logic [31:0] oversize_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(13, 40);
        if (r < 9)
            return $urandom_range(13, 32'h7FFF_FFFF);
        return 32'hFFFF_FFFE;
    endfunction

    // unsigned exp-golomb code
    function automatic void put_ue(input logic [31:0] v);
        logic [32:0] code;
        int          msb;
        code = {1'b0, v} + 33'd1;
        msb  = 0;
        for (int i = 0; i < 33; i++)
            if (code[i])
                msb = i;
        repeat (msb) bit_q.push_back(1'b0);
        for (int i = msb; i >= 0; i--)
            bit_q.push_back(code[i]);
    endfunction

    // header bytes, bits packed msb first, trailing bytes, optional cut
    function automatic void close_set(input int drop, input int extra);
        sps_byte_t        set_q[$];
        logic [DATA_W-1:0] d;
        repeat (HEADER_SKIP_BYTES_DEF) set_q.push_back('{data: 8'($urandom), last: 1'b0});
        while (bit_q.size() % DATA_W != 0)
            bit_q.push_back(1'($urandom));
        while (bit_q.size() != 0)
        begin
            for (int i = DATA_W - 1; i >= 0; i--)
                d[i] = bit_q.pop_front();
            set_q.push_back('{data: d, last: 1'b0});
        end
        repeat (extra) set_q.push_back('{data: 8'($urandom), last: 1'b0});
        repeat (drop)
            if (set_q.size() > 1)
                void'(set_q.pop_back());
        set_q[set_q.size() - 1].last = 1'b1;
        foreach (set_q[i])
            byte_q.push_back(set_q[i]);
        sets_sent++;
    endfunction

    // well-formed parameter set with chosen key fields
    function automatic void make_set(input logic [31:0] sps, input logic [31:0] fn,
                                     input logic [31:0] poc, input logic [31:0] lsb,
                                     input int unsigned cyc, input bit mbs,
                                     input int drop, input int extra);
        bit_q.delete();
        put_ue(sps);
        put_ue(fn);
        put_ue(poc);
        if (poc == 32'd0)
            put_ue(lsb);
        else if (poc == 32'd1)
        begin
            bit_q.push_back(1'($urandom));
            put_ue(filler_value());
            put_ue(filler_value());
            put_ue(cyc);
            repeat (cyc) put_ue(filler_value());
        end
        put_ue(filler_value());
        bit_q.push_back(1'($urandom));
        put_ue(filler_value());
        put_ue(filler_value());
        bit_q.push_back(mbs);
        repeat ($urandom_range(0, 10)) bit_q.push_back(1'($urandom));
        close_set(drop, extra);
    endfunction

    function automatic void make_noise(input int n);
        for (int i = 0; i < n; i++)
            byte_q.push_back('{data: 8'($urandom), last: (i == n - 1)});
        sets_sent++;
    endfunction

    // a code with more leading zeros than the reader allows
    function automatic void make_overlong();
        bit_q.delete();
        put_ue(filler_value());
        if ($urandom_range(0, 1))
            put_ue($urandom_range(0, 12));
        repeat (MAX_GOLOMB_BITS_DEF + $urandom_range(0, 3)) bit_q.push_back(1'b0);
        repeat ($urandom_range(0, 12)) bit_q.push_back(1'($urandom));
        close_set(0, $urandom_range(0, 1));
    endfunction

    function automatic void random_set();
        int          pick;
        int          poc_sel;
        logic [31:0] fn;
        logic [31:0] poc;
        logic [31:0] lsb;
        int unsigned cyc;
        int          drop;
        pick = $urandom_range(0, 99);
        if (pick < 78)
        begin
            fn      = ($urandom_range(0, 9) == 0) ? oversize_value() : $urandom_range(0, 12);
            lsb     = ($urandom_range(0, 9) == 0) ? oversize_value() : $urandom_range(0, 12);
            poc_sel = $urandom_range(0, 9);
            poc     = (poc_sel < 9) ? poc_sel / 3 : $urandom_range(3, 1000);
            cyc     = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
            drop    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
            make_set(filler_value(), fn, poc, lsb, cyc, 1'($urandom), drop,
                     $urandom_range(0, 2));
        end
        else if (pick < 92)
            make_noise($urandom_range(1, 12));
        else
            make_overlong();
    endfunction

    // sender: bursts of requests with random gaps
    task automatic send_req(input sps_byte_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 16);
            gap = $urandom_range(1, 8);
            @(negedge clk);
            payload.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        burst_left--;
        @(negedge clk);
        payload.valid     <= 1'b1;
        payload.data_byte <= item.data;
        payload.last_byte <= item.last;
        do
            @(posedge clk);
        while (!payload.ready);
        bytes_sent++;
    endtask

    task automatic send_all();
        while (byte_q.size() != 0)
            send_req(byte_q.pop_front());
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_results();
        @(negedge clk);
        payload.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    // receiver: stall patterns that change every stretch, plus one long hold
    initial
    begin
        int mode;
        int stretch;
        int phase;
        mode    = 0;
        stretch = 0;
        phase   = 0;
        result.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode    = $urandom_range(0, 3);
                    stretch = $urandom_range(20, 300);
                end
                stretch--;
                phase++;
                case (mode)
                    0: result.ready <= 1'b1;
                    1: result.ready <= 1'($urandom);
                    2: result.ready <= ($urandom_range(0, 7) != 0);
                    default: result.ready <= ((phase % 5) < 2);
                endcase
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (payload.valid && payload.ready) || (result.valid && result.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus and verdict
    initial
    begin
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;
        payload.valid     <= 1'b0;
        payload.data_byte <= '0;
        payload.last_byte <= 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed sets
        filler_small = 1'b1;
        make_noise(1);                                   // set ends inside the header
        make_set(0, 12, 0, 12, 0, 1'b1, 0, 0);           // both sizes at the largest legal value
        make_set(1, 13, 0, 0, 0, 1'b1, 0, 0);            // frame number size too large
        make_set(0, 0, 3, 0, 0, 1'b1, 0, 0);             // invalid poc type
        make_set(0, 1, 1, 0, 2, 1'b0, 0, 1);             // type 1 with a cycle list, bytes after
        make_overlong();                                 // code with too many leading zeros
        send_all();
        wait_results();
        filler_small = 1'b0;

        // random sets
        while (bytes_sent < ITEM_TARGET)
        begin
            if (!held && bytes_sent >= ITEM_TARGET / 3)
            begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
            if (!paused && bytes_sent >= 2 * ITEM_TARGET / 3)
            begin
                wait_results();
                paused = 1'b1;
            end
            random_set();
            send_all();
        end

        wait_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("sent %0d requests in %0d parameter sets (headers, all poc types, cuts, noise)",
                 bytes_sent, sets_sent);
        $display("checked %0d results, %0d of them error reports", results_seen, error_results);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> h264_sps_field_parser.f
+incdir+rtl/core
rtl/core/h264sps_pkg.sv
rtl/core/h264sps_ifs.sv
rtl/core/h264sps_queue.sv
rtl/core/h264sps_front.sv
rtl/core/h264sps_back.sv
rtl/core/h264sps_field_parser.sv
dv/h264_sps_field_parser_checker.sv
dv/h264_sps_field_parser_test.sv
